// File: src/lcg_random_below_bound_assert.svh
// assertion macros used by the checker file
// each macro samples on the rising edge of clk and is disabled while rst_n is low
`ifndef LCG_RANDOM_BELOW_BOUND_ASSERT_SVH
`define LCG_RANDOM_BELOW_BOUND_ASSERT_SVH

// same-cycle implication
`define LRBB_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LRBB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/lrbb_pkg.sv
`default_nettype none

package lrbb_pkg;

    // field widths
    localparam int BOUND_W = 32;
    localparam int VALUE_W = 31;
    localparam int SEED_W  = 32;
    localparam int MULT_W  = 17;
    localparam int PROD_W  = 48;

    // minstd multiplier
    localparam logic [MULT_W-1:0] LCG_MULT = 17'd48271;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // divider step count
    localparam int DIV_STEPS = 32;
    localparam int DCNT_W    = 5;

    // one classified request
    typedef struct packed {
        logic               is_zero;
        logic [VALUE_W-1:0] bound;
    } entry_t;

endpackage

`default_nettype wire

// File: src/lrbb_req_if.sv
`default_nettype none

interface lrbb_req_if;

    logic                                valid;
    logic                                ready;
    logic signed [lrbb_pkg::BOUND_W-1:0] bound;

    modport source (output valid, output bound, input ready);
    modport sink   (input valid, input bound, output ready);

endinterface

`default_nettype wire

// File: src/lrbb_res_if.sv
`default_nettype none

interface lrbb_res_if;

    logic                         valid;
    logic                         ready;
    logic [lrbb_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);

endinterface

`default_nettype wire

// File: src/lcg_random_below_bound.sv
// lcg_random_below_bound: bounded pseudo-random numbers from a minstd generator
//
// request channel carries a signed 32-bit bound; result channel returns one
// 31-bit value per request, in request order. A positive bound advances the
// generator (seed times 48271, folded modulo 2^31-1) and returns the new
// seed minus one reduced modulo the bound; a zero or negative bound returns
// zero and leaves the generator untouched.
// requests enter a two-entry queue, so up to two more are taken while the
// back end works or a result waits.
// a positive bound passes through queue pop, multiply, fold and 32 divider
// steps before its result is valid; a zero or negative bound goes from the
// queue straight to the result register. the back end takes a new item only
// after the result transfer; the remainder divider makes one bit per cycle.
// reset clears the queue and sets the stored seed minus one to zero, so the
// first seed is one. while result.ready is low the result holds steady and
// the queue fills, then request.ready drops.
`default_nettype none

module lcg_random_below_bound
(
    input  wire logic clk,
    input  wire logic rst_n,
    lrbb_req_if.sink   request,
    lrbb_res_if.source result
);

    lrbb_pkg::entry_t q_entry;
    logic             q_valid;
    logic             q_ready;

    // accept and classify
    lrbb_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .q_entry (q_entry),
        .q_valid (q_valid),
        .q_ready (q_ready)
    );

    // generator, divider and result register
    lrbb_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_entry (q_entry),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .result  (result)
    );

endmodule

`default_nettype wire

// File: src/lrbb_front.sv
`default_nettype none

module lrbb_front
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    lrbb_req_if.sink              request,
    output lrbb_pkg::entry_t      q_entry,
    output logic                  q_valid,
    input  wire logic             q_ready
);

    lrbb_pkg::entry_t                  mem_reg [lrbb_pkg::QDEPTH];
    logic [lrbb_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [lrbb_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [lrbb_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                              push, pop;
    lrbb_pkg::entry_t                  new_entry;

    // classify: zero or negative bound gives a zero result and no seed update
    always_comb
    begin
        new_entry.is_zero = (request.bound == '0) || request.bound[lrbb_pkg::BOUND_W-1];
        new_entry.bound   = request.bound[lrbb_pkg::VALUE_W-1:0];
    end

    // queue handshakes
    assign request.ready = (count_reg != lrbb_pkg::QCNT_W'(lrbb_pkg::QDEPTH));
    assign push          = request.valid && request.ready;
    assign q_valid       = (count_reg != '0);
    assign pop           = q_valid && q_ready;
    assign q_entry       = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + lrbb_pkg::QCNT_W'(push) - lrbb_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

`default_nettype wire

// File: src/lrbb_back.sv
`default_nettype none

module lrbb_back
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lrbb_pkg::entry_t q_entry,
    input  wire logic             q_valid,
    output logic                  q_ready,
    lrbb_res_if.source            result
);

    typedef enum logic [4:0]
    {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_FOLD = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [lrbb_pkg::SEED_W-1:0]     smo_reg, smo_next;
    logic [lrbb_pkg::DCNT_W-1:0]     cnt_reg, cnt_next;
    logic [lrbb_pkg::VALUE_W-1:0]    bound_reg, bound_next;
    logic [lrbb_pkg::PROD_W-1:0]     prod_reg, prod_next;
    logic [lrbb_pkg::SEED_W-1:0]     dvd_reg, dvd_next;
    logic [lrbb_pkg::VALUE_W-1:0]    rem_reg, rem_next;

    logic [lrbb_pkg::SEED_W-1:0]     seed;
    logic [lrbb_pkg::PROD_W-1:0]     prod_full;
    logic [lrbb_pkg::VALUE_W-1:0]    fold_sum;
    logic [lrbb_pkg::SEED_W-1:0]     new_smo;
    logic [lrbb_pkg::SEED_W-1:0]     trial;
    logic [lrbb_pkg::SEED_W:0]       diff;

    // seed times multiplier, 32 by 17 bits
    assign seed      = smo_reg + 1'b1;
    assign prod_full = lrbb_pkg::PROD_W'(seed) * lrbb_pkg::PROD_W'(lrbb_pkg::LCG_MULT);

    // end-around carry fold: top 17 bits into the low word, bit 31 dropped
    assign fold_sum = 31'(prod_reg[31:0]
                    + {15'b0, prod_reg[lrbb_pkg::PROD_W-1:32], prod_reg[31]});
    assign new_smo  = {1'b0, fold_sum} - 1'b1;

    // restoring divider step, remainder stays below the bound
    assign trial = {rem_reg, dvd_reg[lrbb_pkg::SEED_W-1]};
    assign diff  = {1'b0, trial} - {2'b0, bound_reg};

    assign q_ready      = (state_reg == S_IDLE);
    assign result.valid = (state_reg == S_OUT);
    assign result.value = rem_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        smo_next   = smo_reg;
        cnt_next   = cnt_reg;
        bound_next = bound_reg;
        prod_next  = prod_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    bound_next = q_entry.bound;
                    if (q_entry.is_zero)
                    begin
                        rem_next   = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = prod_full;
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                smo_next   = new_smo;
                dvd_next   = new_smo;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!diff[lrbb_pkg::SEED_W])
                begin
                    rem_next = diff[lrbb_pkg::VALUE_W-1:0];
                end
                else
                begin
                    rem_next = trial[lrbb_pkg::VALUE_W-1:0];
                end
                dvd_next = {dvd_reg[lrbb_pkg::SEED_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == lrbb_pkg::DCNT_W'(lrbb_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (result.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            smo_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            smo_reg   <= smo_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        bound_reg <= bound_next;
        prod_reg  <= prod_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
    end

endmodule

`default_nettype wire

// File: src/lrbb_checker.sv
`default_nettype none

`include "lcg_random_below_bound_assert.svh"

module lrbb_checker
(
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         req_valid,
    input wire logic                         req_ready,
    input wire logic                         res_valid,
    input wire logic                         res_ready,
    input wire logic [lrbb_pkg::VALUE_W-1:0] res_value
);

    logic [1:0] pend_reg, pend_next;
    logic       req_xfer, res_xfer;

    // requests taken but not yet answered
    assign req_xfer  = req_valid && req_ready;
    assign res_xfer  = res_valid && res_ready;
    assign pend_next = pend_reg + 2'(req_xfer) - 2'(res_xfer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // a stalled result holds
    `LRBB_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_value), "result changed while stalled")

    // no result without an open request
    `LRBB_ASSERT_IMPLY(a_res_owed, res_valid, pend_reg != 2'd0, "result with no open request")

    // back end returns to idle after each result transfer
    `LRBB_ASSERT_NEXT(a_res_gap, res_xfer, !res_valid, "result valid straight after transfer")

    // queue full and one in the back end: no more requests taken
    `LRBB_ASSERT_IMPLY(a_req_full, pend_reg == 2'd3, !req_ready, "request taken beyond capacity")

endmodule

bind lcg_random_below_bound lrbb_checker u_lrbb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_value (result.value)
);

`default_nettype wire

// File: tb/lcg_random_below_bound_tb.sv
module lcg_random_below_bound_tb;

    localparam int RANDOM_ITEMS = 1500;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int DIR_N        = 20;
    localparam logic [31:0] MAX_POS   = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_NEG   = 32'h8000_0000;
    localparam logic [31:0] LOW16     = 32'h0000_FFFF;

    // one directed row: bound, and a hand-typed result where it is obvious
    typedef struct packed {
        logic [31:0]                  bound;
        logic                         fixed;
        logic [lrbb_pkg::VALUE_W-1:0] value;
    } dir_row_t;

    // per-item hint passed from the sender to the monitor
    typedef struct packed {
        logic                         fixed;
        logic [lrbb_pkg::VALUE_W-1:0] value;
    } hint_t;

    logic clk;
    logic rst_n;
    bit   calm;

    lrbb_req_if req_ch();
    lrbb_res_if res_ch();

    lcg_random_below_bound dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (res_ch)
    );

    logic [lrbb_pkg::SEED_W-1:0]  seed_m1;
    logic [lrbb_pkg::VALUE_W-1:0] value_q[$];
    hint_t                        hint_q[$];
    dir_row_t                     directed_rows[DIR_N];
    int                           fail_count;
    int                           results_seen;
    int                           advancing_sent;
    int                           flat_sent;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // minstd step: 16x17 partial products and end-around-carry fold
    function automatic logic [lrbb_pkg::SEED_W-1:0] minstd_fold(
        input logic [lrbb_pkg::SEED_W-1:0] s);
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] low32;
        logic [63:0] top;
        hi    = {48'd0, s[31:16]} * {47'd0, lrbb_pkg::LCG_MULT};
        lo    = {48'd0, s[15:0]} * {47'd0, lrbb_pkg::LCG_MULT};
        hi    = hi + {48'd0, lo[31:16]};
        low32 = {32'd0, hi[15:0], lo[15:0]};
        top   = {48'd0, hi[31:16]};
        top   = top + top + {63'd0, low32[31]};
        low32 = {32'd0, low32[31:0] + top[31:0]};
        return {1'b0, low32[30:0]};
    endfunction

    // bounded draw; a non-positive bound gives zero and keeps the generator
    function automatic logic [lrbb_pkg::VALUE_W-1:0] predict_value(input logic [31:0] b);
        logic [lrbb_pkg::SEED_W-1:0] seed;
        logic [lrbb_pkg::SEED_W-1:0] rem;
        if (b == 32'd0 || b[31])
            return '0;
        seed    = minstd_fold(seed_m1 + 32'd1);
        seed_m1 = seed - 32'd1;
        rem     = seed_m1 % b;
        return rem[lrbb_pkg::VALUE_W-1:0];
    endfunction

    // mix of bound classes, mostly positive so the generator keeps moving
    function automatic logic [31:0] random_bound();
        logic [31:0] r;
        int          pick;
        r    = $urandom();
        pick = $urandom_range(99);
        if (pick < 45)
            return $urandom_range(1, 1000);
        else if (pick < 65)
            return (r[30:0] == 31'd0) ? 32'd1 : {1'b0, r[30:0]};
        else if (pick < 75)
            return 32'd1 << $urandom_range(0, 30);
        else if (pick < 85)
            return r;
        else if (pick < 90)
            return 32'd0;
        else if (pick < 95)
            return {1'b1, r[30:0]};
        else
            return r[0] ? MAX_POS : 32'd1;
    endfunction

    // drive one request and wait for its transfer
    task automatic send_request(input logic [31:0] b, input logic fixed,
                                input logic [lrbb_pkg::VALUE_W-1:0] v);
        while (!calm && $urandom_range(99) < 24)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        hint_q.push_back('{fixed: fixed, value: v});
        req_ch.valid <= 1'b1;
        req_ch.bound <= b;
        if (b == 32'd0 || b[31])
            flat_sent++;
        else
            advancing_sent++;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // hold the request side low until every result is back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (value_q.size() != 0)
            @(posedge clk);
    endtask

    // receiver back-pressure
    always @(posedge clk)
    begin
        res_ch.ready <= calm || ($urandom_range(99) >= 24);
    end

    // monitor: predict on request transfer, compare on result transfer
    always @(posedge clk)
    begin
        hint_t                        h;
        logic [lrbb_pkg::VALUE_W-1:0] pred;
        logic [lrbb_pkg::VALUE_W-1:0] want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                h    = hint_q.pop_front();
                pred = predict_value(req_ch.bound);
                value_q.push_back(h.fixed ? h.value : pred);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (value_q.size() == 0)
                begin
                    $error("value: no result expected, actual %0d", res_ch.value);
                    fail_count++;
                end
                else
                begin
                    want = value_q.pop_front();
                    if (res_ch.value !== want)
                    begin
                        $error("value: expected %0d, actual %0d", want, res_ch.value);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // stimulus
    initial
    begin
        rst_n          = 1'b0;
        calm           = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.bound   = '0;
        res_ch.ready   = 1'b0;
        seed_m1        = '0;
        fail_count     = 0;
        results_seen   = 0;
        advancing_sent = 0;
        flat_sent      = 0;

        // first positive bound after reset sees seed 48271
        directed_rows = '{
            '{MAX_POS,            1'b1, 31'd48270},
            '{32'd0,              1'b1, 31'd0},
            '{32'hFFFF_FFFF,      1'b1, 31'd0},
            '{MIN_NEG,            1'b1, 31'd0},
            '{32'h8000_0001,      1'b1, 31'd0},
            '{32'd1,              1'b1, 31'd0},
            '{32'd2,              1'b0, 31'd0},
            '{32'd3,              1'b0, 31'd0},
            '{32'h7FFF_FFFE,      1'b0, 31'd0},
            '{32'h4000_0000,      1'b0, 31'd0},
            '{32'h0001_0000,      1'b0, 31'd0},
            '{LOW16,              1'b0, 31'd0},
            '{32'h5555_5555,      1'b0, 31'd0},
            '{32'h2AAA_AAAA,      1'b0, 31'd0},
            '{32'd48271,          1'b0, 31'd0},
            '{32'd7,              1'b0, 31'd0},
            '{32'd1,              1'b1, 31'd0},
            '{MAX_POS,            1'b0, 31'd0},
            '{32'hFFFF_0000,      1'b1, 31'd0},
            '{32'h0000_0100,      1'b0, 31'd0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        foreach (directed_rows[i])
            send_request(directed_rows[i].bound, directed_rows[i].fixed,
                         directed_rows[i].value);
        drain_results();

        // random requests, with a quiet stretch and a full drain midway
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= 300 && i < 600);
            if (i == 900)
                drain_results();
            send_request(random_bound(), 1'b0, '0);
        end
        calm = 1'b0;

        // wait for the tail, then a little longer for strays
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d advancing and %0d zero/negative bounds, %0d results checked",
                 advancing_sent, flat_sent, results_seen);
        $display("directed extremes, random bounds, both-side stalls and a mid-run drain");
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
